/* rtl/mclpb_pkg.sv */
// Shared types, layout codes and ROM size constants for the multicart PRG bank mapper.
package mclpb_pkg;

    localparam int ROM_ADDR_BITS = 22;
    localparam int OFFSET_BITS   = 22;
    localparam logic [OFFSET_BITS-1:0] ROM_MASK =
        OFFSET_BITS'((64'd1 << ROM_ADDR_BITS) - 64'd1);

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [2:0] LAYOUT_32K       = 3'd0;
    localparam logic [2:0] LAYOUT_16K_FIXED = 3'd1;
    localparam logic [2:0] LAYOUT_8K_REP    = 3'd2;
    localparam logic [2:0] LAYOUT_16K_DBL   = 3'd3;
    localparam logic [2:0] LAYOUT_32K_ALT   = 3'd4;
    localparam logic [2:0] LAYOUT_8K_LOW    = 3'd5;
    localparam logic [2:0] LAYOUT_8K_ALT    = 3'd6;
    localparam logic [2:0] LAYOUT_16K_ALT   = 3'd7;

    typedef struct packed {
        logic        kind;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic                   rom_hit;
        logic [OFFSET_BITS-1:0] rom_byte_address;
        logic                   write_latched;
        logic                   mirror_horizontal;
    } rsp_t;

endpackage

/* rtl/mclpb_decode.sv */
// Latch window check and PRG address translation for one bus request.
module mclpb_decode
(
    input  mclpb_pkg::req_t  req,
    input  logic             window_low,
    input  logic [15:0]      latched_address,
    input  logic [7:0]       latched_data,
    output logic             latch_en,
    output mclpb_pkg::rsp_t  rsp
);

    logic [7:0]                        bank;
    logic [8:0]                        bank8k;
    logic [2:0]                        layout;
    logic                              mapped;
    logic [mclpb_pkg::OFFSET_BITS-1:0] offset;
    logic [15:0]                       a;

    assign a      = req.cpu_address;
    assign bank   = {latched_address[12], latched_address[4], latched_data[5:0]};
    assign bank8k = {bank, latched_data[7]};
    assign layout = latched_address[2:0];

    assign latch_en = (req.kind == mclpb_pkg::KIND_WRITE) && (a[15:13] == 3'b111)
                      && (window_low || a[12]);

    always_comb
    begin
        mapped = 1'b0;
        offset = '0;
        if (a[15:13] == 3'b011)
        begin
            mapped = (layout == mclpb_pkg::LAYOUT_8K_LOW);
            offset = {bank8k, a[12:0]};
        end
        else if (a[15])
        begin
            mapped = 1'b1;
            unique case (layout)
                mclpb_pkg::LAYOUT_32K,
                mclpb_pkg::LAYOUT_32K_ALT:
                    offset = {bank[7:1], a[14:0]};
                mclpb_pkg::LAYOUT_16K_FIXED:
                    offset = a[14] ? {bank[7:3], 3'b111, a[13:0]} : {bank, a[13:0]};
                mclpb_pkg::LAYOUT_8K_REP,
                mclpb_pkg::LAYOUT_8K_ALT:
                    offset = {bank8k, a[12:0]};
                mclpb_pkg::LAYOUT_16K_DBL,
                mclpb_pkg::LAYOUT_16K_ALT:
                    offset = {bank, a[13:0]};
                mclpb_pkg::LAYOUT_8K_LOW:
                    offset = {bank[7:3], 2'b11, a[14:0]};
            endcase
        end
    end

    always_comb
    begin
        rsp.rom_hit           = (req.kind == mclpb_pkg::KIND_READ) && mapped;
        rsp.rom_byte_address  = rsp.rom_hit ? (offset & mclpb_pkg::ROM_MASK) : '0;
        rsp.write_latched     = latch_en;
        rsp.mirror_horizontal = latch_en ? req.write_data[6] : latched_data[6];
    end

endmodule

/* rtl/multicart_latch_prg_bank_mapper.sv */
// Top level of the multicart PRG bank mapper: request register, latch, result register.
//
//  channel  | signals                        | direction
//  ---------+--------------------------------+----------
//  request  | req_valid req_ready req_data   | in
//  result   | rsp_valid rsp_ready rsp_data   | out
//  config   | cfg_write_enable cfg_write_data| in
//
// One request per cycle sustained while the result side is ready; each request passes the
// request register, the decode and the result register in that order.
// Reset clears the latch, the window select and both valid flags.
// A stalled result holds the request register; a full request register takes no new request until it drains.
module multicart_latch_prg_bank_mapper
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  mclpb_pkg::req_t  req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output mclpb_pkg::rsp_t  rsp_data,
    input  logic             cfg_write_enable,
    input  logic             cfg_write_data
);

    logic             window_low_reg;
    logic             req_valid_reg;
    mclpb_pkg::req_t  req_reg;
    logic             rsp_valid_reg;
    mclpb_pkg::rsp_t  rsp_reg;
    logic [15:0]      latched_address_reg;
    logic [7:0]       latched_data_reg;
    logic             latch_en;
    logic             advance;
    mclpb_pkg::rsp_t  rsp_next;

    mclpb_decode u_decode
    (
        .req             (req_reg),
        .window_low      (window_low_reg),
        .latched_address (latched_address_reg),
        .latched_data    (latched_data_reg),
        .latch_en        (latch_en),
        .rsp             (rsp_next)
    );

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg      <= 1'b0;
            req_valid_reg       <= 1'b0;
            rsp_valid_reg       <= 1'b0;
            latched_address_reg <= '0;
            latched_data_reg    <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                window_low_reg <= cfg_write_data;
            end
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (advance && latch_en)
            begin
                latched_address_reg <= req_reg.cpu_address;
                latched_data_reg    <= req_reg.write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req_data;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.rom_hit && rsp_data.write_latched))
        else $error("result both hit and latched");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.rom_hit) |-> (rsp_data.rom_byte_address == '0))
        else $error("unmapped result carries an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && latch_en) |=> (latched_data_reg == $past(req_reg.write_data)
                                   && rsp_data.mirror_horizontal == latched_data_reg[6]))
        else $error("latch write lost or mirroring stale");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !rsp_valid_reg) |-> req_ready)
        else $error("request stalled with empty result register");

endmodule

/* verif/mclpb_checker.sv */
// Channel monitor for the multicart PRG bank mapper: predicts each result and compares it.
module mclpb_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  mclpb_pkg::req_t  req_data,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  mclpb_pkg::rsp_t  rsp_data,
    input  logic             cfg_write_enable,
    input  logic             cfg_write_data,
    output int               failures,
    output int               pending,
    output int               results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic             window_low;
    logic [15:0]      latch_address;
    logic [7:0]       latch_data;
    mclpb_pkg::rsp_t  predicted_maps[$];
    int               fail_count;
    int               result_count;

    function automatic logic translate(input logic [15:0] addr, input logic [15:0] la,
                                       input logic [7:0] ld,
                                       output logic [mclpb_pkg::OFFSET_BITS-1:0] off);
        logic [7:0]  bank;
        logic [8:0]  bank8k;
        logic [2:0]  layout;
        logic [21:0] r;
        bank   = {la[12], la[4], ld[5:0]};
        bank8k = {bank, ld[7]};
        layout = la[2:0];
        off    = '0;
        if (addr < 16'h6000)
            return 1'b0;
        if (addr < 16'h8000)
        begin
            if (layout != mclpb_pkg::LAYOUT_8K_LOW)
                return 1'b0;
            r = {bank8k, addr[12:0]};
        end
        else
        begin
            case (layout)
                mclpb_pkg::LAYOUT_32K, mclpb_pkg::LAYOUT_32K_ALT:
                    r = {bank[7:1], addr[14:0]};
                mclpb_pkg::LAYOUT_16K_FIXED:
                    r = {((addr < 16'hC000) ? bank : (bank | 8'd7)), addr[13:0]};
                mclpb_pkg::LAYOUT_8K_REP, mclpb_pkg::LAYOUT_8K_ALT:
                    r = {bank8k, addr[12:0]};
                mclpb_pkg::LAYOUT_16K_DBL, mclpb_pkg::LAYOUT_16K_ALT:
                    r = {bank, addr[13:0]};
                default:
                    r = {(bank[7:1] | 7'd3), addr[14:0]};
            endcase
        end
        off = r & mclpb_pkg::ROM_MASK;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mclpb_pkg::rsp_t                   want;
        logic [mclpb_pkg::OFFSET_BITS-1:0] off;
        if (!rst_n)
        begin
            window_low    = 1'b0;
            latch_address = '0;
            latch_data    = '0;
            predicted_maps.delete();
            fail_count    = 0;
            result_count  = 0;
            failures     <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                result_count++;
                if (predicted_maps.size() == 0)
                begin
                    $error("result with no request waiting: %p", rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = predicted_maps.pop_front();
                    if (rsp_data.rom_hit !== want.rom_hit)
                    begin
                        $error("rom_hit expected %0d got %0d", want.rom_hit, rsp_data.rom_hit);
                        fail_count++;
                    end
                    if (rsp_data.rom_byte_address !== want.rom_byte_address)
                    begin
                        $error("rom_byte_address expected %h got %h",
                               want.rom_byte_address, rsp_data.rom_byte_address);
                        fail_count++;
                    end
                    if (rsp_data.write_latched !== want.write_latched)
                    begin
                        $error("write_latched expected %0d got %0d",
                               want.write_latched, rsp_data.write_latched);
                        fail_count++;
                    end
                    if (rsp_data.mirror_horizontal !== want.mirror_horizontal)
                    begin
                        $error("mirror_horizontal expected %0d got %0d",
                               want.mirror_horizontal, rsp_data.mirror_horizontal);
                        fail_count++;
                    end
                end
            end
            if (cfg_write_enable)
                window_low = cfg_write_data;
            if (req_valid && req_ready)
            begin
                want = '0;
                if (req_data.kind == mclpb_pkg::KIND_WRITE)
                begin
                    if (req_data.cpu_address >= (window_low ? 16'hE000 : 16'hF000))
                    begin
                        latch_address      = req_data.cpu_address;
                        latch_data         = req_data.write_data;
                        want.write_latched = 1'b1;
                    end
                end
                else if (translate(req_data.cpu_address, latch_address, latch_data, off))
                begin
                    want.rom_hit          = 1'b1;
                    want.rom_byte_address = off;
                end
                want.mirror_horizontal = latch_data[6];
                predicted_maps.push_back(want);
            end
            failures     <= fail_count;
            pending      <= predicted_maps.size();
            results_seen <= result_count;
        end
    end

endmodule

/* verif/testbench.sv */
// Top of the mapper testbench: clock, reset, request and window stimulus, result stalls, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    mclpb_pkg::req_t  req_data;
    logic             rsp_valid;
    logic             rsp_ready;
    mclpb_pkg::rsp_t  rsp_data;
    logic             cfg_write_enable;
    logic             cfg_write_data;
    logic             quiet;
    int               failures;
    int               pending;
    int               results_seen;
    int               requests_sent;
    int               window_writes;

    multicart_latch_prg_bank_mapper dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req_data         (req_data),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp_data         (rsp_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    mclpb_checker watch
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req_data         (req_data),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp_data         (rsp_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .failures         (failures),
        .pending          (pending),
        .results_seen     (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("multicart_latch_prg_bank_mapper: mismatch");
        $finish;
    end

    function automatic mclpb_pkg::req_t make_req(input logic kind, input logic [15:0] addr,
                                                 input logic [7:0] data);
        mclpb_pkg::req_t r;
        r.kind        = kind;
        r.cpu_address = addr;
        r.write_data  = data;
        return r;
    endfunction

    task automatic send_request(input mclpb_pkg::req_t r);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic write_window(input logic value);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        window_writes++;
    endtask

    // stall the result side in random bursts until the final phase
    initial
    begin
        int hold;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 19);
                rsp_ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int               pick;
        logic             window;
        mclpb_pkg::req_t  r;
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req_data         = '0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = 1'b0;
        quiet            = 1'b0;
        requests_sent    = 0;
        window_writes    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_request(make_req(mclpb_pkg::KIND_READ,  16'h0000, 8'hFF));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h6000, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hFFFF, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hEFFF, 8'hFF));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'h5000, 8'h40));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hF011, 8'h7F));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hBFFF, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hC000, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hF002, 8'h80));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hA000, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hE001, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hFFF3, 8'hC5));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h8000, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hC123, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hF005, 8'hFF));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h6000, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h7FFF, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h5FFF, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'hFFFF, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hF016, 8'h40));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h9FFF, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hF007, 8'h3F));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h8000, 8'h00));
        write_window(1'b1);
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hE000, 8'hBF));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h8000, 8'h00));
        send_request(make_req(mclpb_pkg::KIND_WRITE, 16'hE005, 8'hFF));
        send_request(make_req(mclpb_pkg::KIND_READ,  16'h6000, 8'h00));

        for (int phase = 0; phase < 8; phase++)
        begin
            window = phase[0];
            write_window(window);
            if (phase == 7)
                quiet = 1'b1;
            for (int n = 0; n < 200; n++)
            begin
                pick         = $urandom_range(0, 99);
                r.write_data = 8'($urandom);
                if (pick < 30)
                begin
                    r.kind        = mclpb_pkg::KIND_WRITE;
                    r.cpu_address = 16'($urandom_range(window ? 16'hE000 : 16'hF000, 16'hFFFF));
                end
                else if (pick < 40)
                begin
                    r.kind        = mclpb_pkg::KIND_WRITE;
                    r.cpu_address = 16'($urandom);
                end
                else if (pick < 88)
                begin
                    r.kind        = mclpb_pkg::KIND_READ;
                    r.cpu_address = 16'($urandom_range(16'h6000, 16'hFFFF));
                end
                else
                begin
                    r.kind        = mclpb_pkg::KIND_READ;
                    r.cpu_address = 16'($urandom);
                end
                send_request(r);
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("sent %0d bus accesses, checked %0d results, over %0d latch window writes",
                 requests_sent, results_seen, window_writes);
        if (failures == 0 && pending == 0)
            $display("multicart_latch_prg_bank_mapper: match");
        else
            $display("multicart_latch_prg_bank_mapper: mismatch");
        $finish;
    end

endmodule
